### src/aiq_pkg.sv
package aiq_pkg;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_INDEX_BITS = 2;

   localparam logic [REG_INDEX_BITS-1:0] REG_MODE        = 2'd0;
   localparam logic [REG_INDEX_BITS-1:0] REG_INV_SCALE   = 2'd1;
   localparam logic [REG_INDEX_BITS-1:0] REG_CODE_OFFSET = 2'd2;

   localparam logic        MODE_INT8 = 1'b0;
   localparam logic        MODE_INT4 = 1'b1;

   localparam logic [31:0] INV_SCALE_RESET   = 32'd65536;
   localparam logic [7:0]  CODE_OFFSET_RESET = 8'd0;

   localparam logic [7:0]  CODE8_TOP   = 8'd255;
   localparam logic [7:0]  CODE4_TOP   = 8'd15;
   localparam logic [3:0]  NIBBLE_ZERO = 4'h0;

   typedef struct packed {
      logic        mode;
      logic [31:0] inv_scale;
      logic [7:0]  code_offset;
      logic        mode_write;
   } aiq_cfg_type;

endpackage

### src/aiq_csr.sv
module aiq_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [aiq_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [aiq_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [aiq_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready,
   output aiq_pkg::aiq_cfg_type                cfg
);
   import aiq_pkg::*;

   logic                      mode_ff, mode_in;
   logic [31:0]               inv_scale_ff, inv_scale_in;
   logic [7:0]                code_offset_ff, code_offset_in;
   logic                      wr_en;
   logic [REG_INDEX_BITS-1:0] reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[CSR_ADDR_BITS-1:2];

   always_comb begin
      mode_in        = mode_ff;
      inv_scale_in   = inv_scale_ff;
      code_offset_in = code_offset_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_MODE:        mode_in        = csr_pwdata[0];
            REG_INV_SCALE:   inv_scale_in   = csr_pwdata[31:0];
            REG_CODE_OFFSET: code_offset_in = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_INT8;
         inv_scale_ff   <= INV_SCALE_RESET;
         code_offset_ff <= CODE_OFFSET_RESET;
      end else begin
         mode_ff        <= mode_in;
         inv_scale_ff   <= inv_scale_in;
         code_offset_ff <= code_offset_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_MODE:        csr_prdata = {{(CSR_DATA_BITS-1){1'b0}}, mode_ff};
         REG_INV_SCALE:   csr_prdata = inv_scale_ff;
         REG_CODE_OFFSET: csr_prdata = {{(CSR_DATA_BITS-8){1'b0}}, code_offset_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg.mode        = mode_ff;
   assign cfg.inv_scale   = inv_scale_ff;
   assign cfg.code_offset = code_offset_ff;
   assign cfg.mode_write  = wr_en && (reg_index == REG_MODE);

endmodule

### src/aiq_mult.sv
module aiq_mult #(
   parameter int SAMPLE_BITS = 32,
   parameter int PROD_W      = SAMPLE_BITS + 33
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_last,
   input  logic [31:0]            inv_scale,
   output logic                   prod_valid,
   input  logic                   prod_ready,
   output logic [PROD_W-1:0]      prod,
   output logic                   prod_last
);

   logic                   s0_valid_ff, s0_valid_in;
   logic [SAMPLE_BITS-1:0] s0_sample_ff;
   logic                   s0_last_ff;
   logic                   s1_valid_ff, s1_valid_in;
   logic [PROD_W-1:0]      s1_prod_ff, s1_prod_in;
   logic                   s1_last_ff;
   logic                   s0_load;
   logic                   s1_load;

   // The product stage moves whenever it is empty or its holder is drained.
   assign s1_load   = !s1_valid_ff || prod_ready;
   assign s0_load   = !s0_valid_ff || s1_load;
   assign req_stall = !s0_load;

   assign s0_valid_in = s0_load ? req_valid : s0_valid_ff;
   assign s1_valid_in = s1_load ? s0_valid_ff : s1_valid_ff;

   // Unsigned scale is widened by one zero bit so the product is signed.
   assign s1_prod_in = PROD_W'($signed(s0_sample_ff) * $signed({1'b0, inv_scale}));

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_load) begin
         s0_sample_ff <= req_sample;
         s0_last_ff   <= req_last;
      end
      if (s1_load) begin
         s1_prod_ff <= s1_prod_in;
         s1_last_ff <= s0_last_ff;
      end
   end

   assign prod_valid = s1_valid_ff;
   assign prod       = s1_prod_ff;
   assign prod_last  = s1_last_ff;

endmodule

### src/aiq_pack.sv
module aiq_pack #(
   parameter int PROD_W    = 65,
   parameter int PROD_FRAC = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  aiq_pkg::aiq_cfg_type cfg,
   input  logic                 prod_valid,
   output logic                 prod_ready,
   input  logic [PROD_W-1:0]    prod,
   input  logic                 prod_last,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_code,
   output logic                 rsp_final_res
);
   import aiq_pkg::*;

   // One spare bit above whichever is wider: the product or the offset term.
   localparam int SUM_W = ((PROD_W > PROD_FRAC + 9) ? PROD_W : PROD_FRAC + 9) + 1;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        code_ff, code_in;
   logic              final_ff, final_in;
   logic [3:0]        held_nibble_ff, held_nibble_in;
   logic              waiting_ff, waiting_in;
   logic              take;
   logic              emit;
   logic [7:0]        top;
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] hi;
   logic [SUM_W-1:0]  sum_clamped;
   logic [7:0]        q_code;

   assign prod_ready = !rsp_valid_ff || !rsp_stall;
   assign take       = prod_valid && prod_ready;

   assign top = (cfg.mode == MODE_INT4) ? CODE4_TOP : CODE8_TOP;
   assign sum = $signed({{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod})
              + $signed({{(SUM_W-8-PROD_FRAC){1'b0}}, cfg.code_offset, {PROD_FRAC{1'b0}}});
   assign hi  = $signed({{(SUM_W-8-PROD_FRAC){1'b0}}, top, {PROD_FRAC{1'b0}}});

   always_comb begin
      priority if (sum[SUM_W-1]) begin
         sum_clamped = '0;
      end else if (sum > hi) begin
         sum_clamped = hi;
      end else begin
         sum_clamped = sum;
      end
   end

   // Round half up; a value clamped to the top has a zero fraction, so no carry out.
   assign q_code = sum_clamped[PROD_FRAC+7:PROD_FRAC] + {7'd0, sum_clamped[PROD_FRAC-1]};

   always_comb begin
      emit           = 1'b0;
      code_in        = code_ff;
      final_in       = final_ff;
      held_nibble_in = held_nibble_ff;
      waiting_in     = waiting_ff;
      if (take) begin
         priority if (cfg.mode == MODE_INT8) begin
            emit     = 1'b1;
            code_in  = q_code;
            final_in = prod_last;
         end else if (waiting_ff) begin
            emit           = 1'b1;
            code_in        = {held_nibble_ff, q_code[3:0]};
            final_in       = prod_last;
            held_nibble_in = NIBBLE_ZERO;
            waiting_in     = 1'b0;
         end else if (prod_last) begin
            // Unpaired final sample goes out alone with an empty low nibble.
            emit     = 1'b1;
            code_in  = {q_code[3:0], NIBBLE_ZERO};
            final_in = 1'b1;
         end else begin
            held_nibble_in = q_code[3:0];
            waiting_in     = 1'b1;
         end
      end
      if (cfg.mode_write) begin
         held_nibble_in = NIBBLE_ZERO;
         waiting_in     = 1'b0;
      end
   end

   assign rsp_valid_in = prod_ready ? emit : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         waiting_ff     <= 1'b0;
         held_nibble_ff <= NIBBLE_ZERO;
      end else begin
         rsp_valid_ff   <= rsp_valid_in;
         waiting_ff     <= waiting_in;
         held_nibble_ff <= held_nibble_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         code_ff  <= code_in;
         final_ff <= final_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code      = code_ff;
   assign rsp_final_res = final_ff;

endmodule

### src/affine_int8_int4_quantizer_top.sv
// An accepted request passes through the input register, then the product register,
// then the result register; the 32x33 multiply and the clamp each own a stage.
// Throughput: one request per cycle while rsp_stall does not hold the pipeline.
// In int4 mode the first sample of a pair produces no result.
// Reset is synchronous and active high; it clears stage valids, pair state and CSRs.
module affine_int8_int4_quantizer_top #(
   parameter int SAMPLE_BITS = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [SAMPLE_BITS-1:0]             req_sample,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [7:0]                         rsp_code,
   output logic                               rsp_final_res,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [aiq_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [aiq_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [aiq_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);
   import aiq_pkg::*;

   localparam int PROD_W    = SAMPLE_BITS + 33;
   localparam int PROD_FRAC = FRAC_BITS + 16;

   aiq_cfg_type       cfg;
   logic              prod_valid;
   logic              prod_ready;
   logic [PROD_W-1:0] prod;
   logic              prod_last;

   aiq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   aiq_mult #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .PROD_W      (PROD_W)
   ) u_mult (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .req_last   (req_last),
      .inv_scale  (cfg.inv_scale),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod       (prod),
      .prod_last  (prod_last)
   );

   aiq_pack #(
      .PROD_W    (PROD_W),
      .PROD_FRAC (PROD_FRAC)
   ) u_pack (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .prod_valid    (prod_valid),
      .prod_ready    (prod_ready),
      .prod          (prod),
      .prod_last     (prod_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_code      (rsp_code),
      .rsp_final_res (rsp_final_res)
   );

endmodule
